// ----- rtl/core/css_pkg.sv -----
// ----------------------------------------------------------------------------
// css_pkg
// Types, codes and helpers shared by the substring search controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package css_pkg;

    // item kinds carried on the input tuser bit
    localparam logic KIND_NEEDLE = 1'b0;
    localparam logic KIND_TEXT   = 1'b1;

    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;

    localparam int RESULT_BITS = 18;
    localparam int TDATA_BITS  = 24;

    typedef enum logic {
        ST_CLOSED,
        ST_LOADING
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_needle;
        logic wr_needle;
        logic text_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;
    } t_status;

    function automatic logic [7:0] fold_byte(logic [7:0] c, logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/caseless_substring_search_top.sv -----
// ----------------------------------------------------------------------------
// caseless_substring_search_top
// First-occurrence needle search over a byte stream, optional ASCII case fold.
// ----------------------------------------------------------------------------
// The needle store and the chain of per-position match cells update in the
// cycle a byte is accepted, so bytes may arrive back to back. The single result
// of a text sits in an output register; input stalls only while that register
// is full and the output side is not ready. Load the needle with tuser low
// (tlast on its final byte), then stream text with tuser high (tlast on its
// final byte). One result per text: found with the start index at the first
// match, or not found at the text end.
// ----------------------------------------------------------------------------
module caseless_substring_search_top #(
    parameter int NEEDLE_MAX      = 32,
    parameter int TEXT_INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,   // case_fold
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // data_byte
    input  logic        i_s_tuser,    // kind
    input  logic        i_s_tlast,    // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata     // found, match_position[15:0], needle_too_long, zero pad
);

    css_pkg::t_cmd                   cmd;
    css_pkg::t_status                status;
    logic [css_pkg::RESULT_BITS-1:0] result;
    logic                            s_accept;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_m_tdata   = {(css_pkg::TDATA_BITS - css_pkg::RESULT_BITS)'(0), result};

    css_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    css_datapath #(
        .NEEDLE_MAX      (NEEDLE_MAX),
        .TEXT_INDEX_BITS (TEXT_INDEX_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_fold  (i_cfg_data),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while result register full");

    a_needle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tuser == css_pkg::KIND_NEEDLE && !(o_m_tvalid && !i_m_tready))
        |=> !o_m_tvalid)
        else $error("needle byte produced a result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

// ----- rtl/core/css_ctrl.sv -----
// ----------------------------------------------------------------------------
// css_ctrl
// Needle load state machine, input/output handshake and datapath commands.
// ----------------------------------------------------------------------------
module css_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tuser,
    input  logic              i_s_tlast,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  css_pkg::t_status  i_status,
    output css_pkg::t_cmd     o_cmd
);

    css_pkg::t_state r_state;
    css_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            s_accept;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        if (s_accept) begin
            if (i_s_tuser == css_pkg::KIND_TEXT) begin
                n_state = css_pkg::ST_CLOSED;
            end else if (i_s_tlast) begin
                n_state = css_pkg::ST_CLOSED;
            end else begin
                n_state = css_pkg::ST_LOADING;
            end
        end
    end

    // outputs
    always_comb begin
        o_s_tready       = !r_out_valid || i_m_tready;
        o_cmd.wr_needle  = s_accept && (i_s_tuser == css_pkg::KIND_NEEDLE);
        o_cmd.text_step  = s_accept && (i_s_tuser == css_pkg::KIND_TEXT);
        o_cmd.out_load   = o_cmd.text_step && i_status.emit;
        case (r_state)
            css_pkg::ST_CLOSED:  o_cmd.clr_needle = o_cmd.wr_needle;
            css_pkg::ST_LOADING: o_cmd.clr_needle = 1'b0;
            default:             o_cmd.clr_needle = 1'b0;
        endcase
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= css_pkg::ST_CLOSED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/core/css_datapath.sv -----
// ----------------------------------------------------------------------------
// css_datapath
// Needle store, per-position match cells, text index and result register.
// ----------------------------------------------------------------------------
module css_datapath #(
    parameter int NEEDLE_MAX      = 32,
    parameter int TEXT_INDEX_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_write,
    input  logic                            i_cfg_fold,
    input  logic [7:0]                      i_byte,
    input  logic                            i_last,
    input  css_pkg::t_cmd                   i_cmd,
    output css_pkg::t_status                o_status,
    output logic [css_pkg::RESULT_BITS-1:0] o_result
);

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int WW    = (TEXT_INDEX_BITS > 16) ? TEXT_INDEX_BITS : 16;

    logic [7:0]                 r_store [NEEDLE_MAX];
    logic [LEN_W-1:0]           r_len;
    logic [NEEDLE_MAX-1:0]      r_flags;
    logic [NEEDLE_MAX-1:0]      n_flags;
    logic [TEXT_INDEX_BITS-1:0] r_idx;
    logic                       r_reported;
    logic                       r_overflow;
    logic                       r_case_fold;
    logic                       r_found;
    logic [15:0]                r_pos;
    logic                       r_ntl;

    logic [LEN_W-1:0]           eff_len;
    logic [7:0]                 text_c;
    logic                       cell_hit;
    logic                       hit;
    logic                       idx_sat;
    logic [WW-1:0]              diff;
    logic [15:0]                n_pos;

    assign eff_len = i_cmd.clr_needle ? '0 : r_len;
    assign text_c  = css_pkg::fold_byte(i_byte, r_case_fold);
    assign idx_sat = (r_idx == '1);

    // match cells: one per needle position
    for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_first
            assign prev = 1'b1;
        end else begin : g_rest
            assign prev = r_flags[k-1];
        end
        assign n_flags[k] = (LEN_W'(k) < r_len) && prev &&
                            (css_pkg::fold_byte(r_store[k], r_case_fold) == text_c);

        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_needle && eff_len == LEN_W'(k)) begin
                r_store[k] <= i_byte;
            end
        end
    end

    always_comb begin
        cell_hit = 1'b0;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
            if (r_len == LEN_W'(k + 1) && n_flags[k]) begin
                cell_hit = 1'b1;
            end
        end
        hit = (r_len == '0) ? (r_idx == '0) : cell_hit;
    end

    assign o_status.emit = !r_reported && (hit || i_last);

    always_comb begin
        diff = WW'(r_idx) - WW'(r_len) + WW'(1);
        if (idx_sat) begin
            n_pos = css_pkg::POS_MAX;
        end else if (r_len == '0) begin
            n_pos = '0;
        end else if (diff > WW'(css_pkg::POS_MAX)) begin
            n_pos = css_pkg::POS_MAX;
        end else begin
            n_pos = diff[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_flags     <= '0;
            r_idx       <= '0;
            r_reported  <= 1'b0;
            r_overflow  <= 1'b0;
            r_case_fold <= 1'b1;
        end else begin
            if (i_cfg_write) begin
                r_case_fold <= i_cfg_fold;
            end
            if (i_cmd.wr_needle) begin
                if (i_cmd.clr_needle) begin
                    r_flags    <= '0;
                    r_idx      <= '0;
                    r_reported <= 1'b0;
                end
                if (eff_len < LEN_W'(NEEDLE_MAX)) begin
                    r_len      <= eff_len + LEN_W'(1);
                    r_overflow <= i_cmd.clr_needle ? 1'b0 : r_overflow;
                end else begin
                    r_len      <= eff_len;
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.text_step) begin
                if (i_last) begin
                    r_flags    <= '0;
                    r_idx      <= '0;
                    r_reported <= 1'b0;
                end else begin
                    r_flags <= n_flags;
                    if (!idx_sat) begin
                        r_idx <= r_idx + TEXT_INDEX_BITS'(1);
                    end
                    if (hit) begin
                        r_reported <= 1'b1;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_found <= hit;
            r_pos   <= hit ? n_pos : '0;
            r_ntl   <= r_overflow;
        end
    end

    assign o_result = {r_ntl, r_pos, r_found};

endmodule
